// File: rtl/odc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package odc_pkg;

	localparam int MAX_WHEELS = 4;
	localparam int WHEEL_W = 2;
	localparam int CNT_W = 32;
	localparam int DIFF_W = CNT_W + 1;
	localparam int TPR_W = 16;
	localparam int MASK_W = 4;
	localparam int RPM_W = 16;
	localparam int DIV_W = 32;
	localparam int RECIP_W = 2 * DIV_W;
	localparam int PROD_W = 40;
	localparam int Q5_W = 30;
	localparam int CFG_IDX_W = 1;
	localparam int DEF_QUEUE_DEPTH = 2;

	localparam logic [9:0] TPM_SCALE = 10'd600;
	localparam logic [2:0] POLL_LIMIT = 3'd5;
	localparam logic [DIV_W-1:0] DIV5_RECIP = 32'hCCCC_CCCD;
	localparam int DIV5_SHIFT = 34;
	localparam logic [TPR_W-1:0] TPR_RESET = 16'd1980;
	localparam logic [MASK_W-1:0] MASK_RESET = 4'd10;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_REV = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_MASK = 1'd1;

	typedef struct packed {
		logic [MASK_W-1:0] a_levels;
		logic [MASK_W-1:0] b_levels;
		logic              poll_tick;
		logic              clear_wheel;
		logic [WHEEL_W-1:0] wheel;
	} odc_in_t;

	typedef struct packed {
		logic signed [CNT_W-1:0] ticks;
		logic signed [CNT_W-1:0] ticks_per_minute;
		logic signed [RPM_W-1:0] rpm;
	} odc_out_t;

	typedef struct packed {
		logic [CNT_W-1:0]                     ticks;
		logic                                 sel_ok;
		logic [WHEEL_W-1:0]                   wheel;
		logic                                 update;
		logic [MAX_WHEELS-1:0][DIFF_W-1:0]    diff;
	} odc_job_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [TPR_W-1:0] divisor;
	} odc_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} odc_div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/odc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module odc_front import odc_pkg::*; #(
	parameter int NUM_WHEELS = MAX_WHEELS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire odc_in_t           item,
	input  wire logic [MASK_W-1:0] reverse_mask,
	output odc_job_t               job
);

	localparam int WI_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

	logic [NUM_WHEELS-1:0] last_a_q;
	logic [CNT_W-1:0]      count_q [NUM_WHEELS];
	logic [CNT_W-1:0]      snap_q [NUM_WHEELS];
	logic [CNT_W-1:0]      count_n [NUM_WHEELS];
	logic [CNT_W-1:0]      snap_n [NUM_WHEELS];
	logic [CNT_W-1:0]      snap_c [NUM_WHEELS];
	logic [2:0]            poll_q;
	logic [2:0]            poll_inc;
	logic                  update;
	logic                  sel_ok;
	logic [NUM_WHEELS-1:0] rising;

	assign rising   = item.a_levels[NUM_WHEELS-1:0] & ~last_a_q;
	assign poll_inc = poll_q + 3'd1;
	assign update   = item.poll_tick && (poll_inc >= POLL_LIMIT);
	assign sel_ok   = int'(item.wheel) < NUM_WHEELS;

	always_comb begin
		job = '0;
		for (int w = 0; w < NUM_WHEELS; w++) begin
			count_n[w] = count_q[w];
			if (rising[w]) begin
				count_n[w] = (item.b_levels[w] == reverse_mask[w]) ?
					count_q[w] + 32'd1 : count_q[w] - 32'd1;
			end
			snap_c[w] = snap_q[w];
			if (item.clear_wheel && (item.wheel == WHEEL_W'(w))) begin
				count_n[w] = '0;
				snap_c[w]  = '0;
			end
			snap_n[w] = update ? count_n[w] : snap_c[w];
			job.diff[w] = {count_n[w][CNT_W-1], count_n[w]} - {snap_c[w][CNT_W-1], snap_c[w]};
		end
		job.sel_ok = sel_ok;
		job.wheel  = item.wheel;
		job.update = update;
		job.ticks  = sel_ok ? count_n[item.wheel[WI_W-1:0]] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_a_q <= '0;
			poll_q   <= '0;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				count_q[w] <= '0;
				snap_q[w]  <= '0;
			end
		end else if (take) begin
			last_a_q <= item.a_levels[NUM_WHEELS-1:0];
			if (item.poll_tick) begin
				poll_q <= update ? 3'd0 : poll_inc;
			end
			for (int w = 0; w < NUM_WHEELS; w++) begin
				count_q[w] <= count_n[w];
				snap_q[w]  <= snap_n[w];
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/odc_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module odc_fifo import odc_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire odc_job_t push_data,
	output logic          full,
	input  wire logic     pop,
	output odc_job_t      pop_data,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	odc_job_t         mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [LVL_W-1:0] lvl_q;

	assign full     = lvl_q == LVL_W'(DEPTH);
	assign empty    = lvl_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			lvl_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   lvl_q <= lvl_q + LVL_W'(1);
				2'b01:   lvl_q <= lvl_q - LVL_W'(1);
				default: lvl_q <= lvl_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/odc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module odc_div import odc_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire odc_div_req_t req,
	output odc_div_rsp_t      rsp
);

	localparam int STEP_W = $clog2(DIV_W);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TPR_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [TPR_W-1:0]  dvs_q;
	logic [TPR_W:0]    trial;
	logic              fits;
	logic [TPR_W-1:0]  rem_n;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign rem_n = fits ? TPR_W'(trial - {1'b0, dvs_q}) : trial[TPR_W-1:0];

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

endmodule

`default_nettype wire

// File: rtl/odc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module odc_back import odc_pkg::*; #(
	parameter int NUM_WHEELS = MAX_WHEELS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             job_valid,
	input  wire odc_job_t         job,
	output logic                  job_pop,
	input  wire logic [TPR_W-1:0] ticks_per_rev,
	output odc_div_req_t          div_req,
	input  wire odc_div_rsp_t     div_rsp,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output odc_out_t              out_data
);

	localparam int WI_W = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SPD_GO   = 6'b000010,
		ST_SPD_MUL  = 6'b000100,
		ST_SPD_SAT  = 6'b001000,
		ST_RPM_GO   = 6'b010000,
		ST_RPM_WAIT = 6'b100000
	} odc_state_t;

	odc_state_t        state_q;
	logic              done_wait_q;
	odc_job_t          job_q;
	logic [WI_W-1:0]   w_q;
	logic              neg_q;
	logic [Q5_W-1:0]   q5_q;
	logic [PROD_W-1:0] prod_q;
	logic [RPM_W-1:0]  rpm_q;
	logic [CNT_W-1:0]  speed_q [NUM_WHEELS];
	logic              out_valid_q;
	odc_out_t          out_data_q;

	logic [DIFF_W-1:0]  diff_sel;
	logic [DIFF_W-1:0]  diff_mag;
	logic [RECIP_W-1:0] recip_prod;
	logic [CNT_W-1:0]   spd_sel;
	logic [CNT_W-1:0]   spd_mag;
	logic [CNT_W-1:0]   spd_sat;
	logic [RPM_W-1:0]   rpm_sat;
	logic               rpm_skip;
	logic               load_out;

	assign diff_sel   = job_q.diff[WHEEL_W'(w_q)];
	assign diff_mag   = diff_sel[DIFF_W-1] ? DIFF_W'(-diff_sel) : diff_sel;
	assign recip_prod = RECIP_W'(diff_mag[DIV_W-1:0]) * RECIP_W'(DIV5_RECIP);
	assign spd_sel    = speed_q[job_q.wheel[WI_W-1:0]];
	assign spd_mag    = spd_sel[CNT_W-1] ? CNT_W'(-spd_sel) : spd_sel;
	assign rpm_skip   = !job_q.sel_ok || (ticks_per_rev == '0);
	assign load_out   = done_wait_q && (!out_valid_q || out_ready);

	always_comb begin
		if (!neg_q) begin
			spd_sat = (prod_q > PROD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : prod_q[CNT_W-1:0];
		end else begin
			spd_sat = (prod_q > PROD_W'(32'h8000_0000)) ? 32'h8000_0000 :
				CNT_W'(~prod_q[CNT_W-1:0] + 32'd1);
		end
	end

	always_comb begin
		if (!neg_q) begin
			rpm_sat = (div_rsp.quotient > 32'd32767) ? 16'h7FFF :
				div_rsp.quotient[RPM_W-1:0];
		end else begin
			rpm_sat = (div_rsp.quotient > 32'd32768) ? 16'h8000 :
				RPM_W'(~div_rsp.quotient[RPM_W-1:0] + 16'd1);
		end
	end

	always_comb begin
		div_req = '0;
		job_pop = (state_q == ST_IDLE) && !done_wait_q && job_valid;
		if ((state_q == ST_RPM_GO) && !rpm_skip) begin
			div_req.start    = 1'b1;
			div_req.dividend = spd_mag;
			div_req.divisor  = ticks_per_rev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_wait_q <= 1'b0;
			out_valid_q <= 1'b0;
			w_q         <= '0;
			for (int w = 0; w < NUM_WHEELS; w++) begin
				speed_q[w] <= '0;
			end
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				done_wait_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						w_q     <= '0;
						state_q <= job.update ? ST_SPD_GO : ST_RPM_GO;
					end
				end
				ST_SPD_GO: begin
					state_q <= ST_SPD_MUL;
				end
				ST_SPD_MUL: begin
					state_q <= ST_SPD_SAT;
				end
				ST_SPD_SAT: begin
					speed_q[w_q] <= spd_sat;
					if (w_q == WI_W'(NUM_WHEELS - 1)) begin
						state_q <= ST_RPM_GO;
					end else begin
						w_q     <= w_q + WI_W'(1);
						state_q <= ST_SPD_GO;
					end
				end
				ST_RPM_GO: begin
					if (rpm_skip) begin
						done_wait_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_RPM_WAIT;
					end
				end
				ST_RPM_WAIT: begin
					if (div_rsp.done) begin
						done_wait_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
		end
		if (state_q == ST_SPD_GO) begin
			neg_q <= diff_sel[DIFF_W-1];
			q5_q  <= recip_prod[DIV5_SHIFT +: Q5_W];
		end
		if (state_q == ST_SPD_MUL) begin
			prod_q <= PROD_W'(q5_q) * PROD_W'(TPM_SCALE);
		end
		if (state_q == ST_RPM_GO) begin
			neg_q <= spd_sel[CNT_W-1];
			rpm_q <= '0;
		end
		if ((state_q == ST_RPM_WAIT) && div_rsp.done) begin
			rpm_q <= rpm_sat;
		end
		if (load_out) begin
			out_data_q.ticks            <= job_q.sel_ok ? job_q.ticks : '0;
			out_data_q.ticks_per_minute <= job_q.sel_ok ? spd_sel : '0;
			out_data_q.rpm              <= rpm_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// File: rtl/wheel_odometry_counter_top.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_ready   in_data   (odc_in_t)
// out       output     out_valid / out_ready out_data  (odc_out_t)
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The front takes one request per cycle while the job queue (QUEUE_DEPTH) has room.
// The back takes one request at a time, using the 32-step serial divider for rpm;
// a request with zero ticks_per_rev or an absent wheel skips the divider.
// Every fifth poll adds the speed updates: one pass of SPD_GO, SPD_MUL, SPD_SAT per wheel.
// Reset clears counts, snapshots, speeds and the poll count; config takes its defaults.
// A stalled out channel holds one result; the front keeps filling the queue meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module wheel_odometry_counter_top import odc_pkg::*; #(
	parameter int NUM_WHEELS  = MAX_WHEELS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire odc_in_t              in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output odc_out_t                  out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TPR_W-1:0]     cfg_data
);

	logic [TPR_W-1:0]  tpr_q;
	logic [MASK_W-1:0] rev_q;
	logic              take;
	logic              q_full;
	logic              q_empty;
	logic              q_pop;
	odc_job_t          job;
	odc_job_t          head;
	odc_div_req_t      div_req;
	odc_div_rsp_t      div_rsp;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign take      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpr_q <= TPR_RESET;
			rev_q <= MASK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TICKS_PER_REV: tpr_q <= cfg_data;
				REG_REVERSE_MASK:  rev_q <= cfg_data[MASK_W-1:0];
				default:           tpr_q <= tpr_q;
			endcase
		end
	end

	odc_front #(
		.NUM_WHEELS(NUM_WHEELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item         (in_data),
		.reverse_mask (rev_q),
		.job          (job)
	);

	odc_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (job),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (head),
		.empty     (q_empty)
	);

	odc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	odc_back #(
		.NUM_WHEELS(NUM_WHEELS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (!q_empty),
		.job           (head),
		.job_pop       (q_pop),
		.ticks_per_rev (tpr_q),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data)
	);

	a_rpm_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.rpm == '0 ||
			out_data.rpm[RPM_W-1] == out_data.ticks_per_minute[CNT_W-1]))
		else $error("rpm sign disagrees with ticks per minute");

	a_rpm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.ticks_per_minute == '0) |-> out_data.rpm == '0)
		else $error("nonzero rpm at zero speed");

	a_clear_wins: assert property (@(posedge clk) disable iff (!arst_n)
		(take && in_data.clear_wheel && (int'(in_data.wheel) < NUM_WHEELS)) |->
			job.ticks == '0)
		else $error("cleared wheel reports nonzero ticks");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import odc_pkg::*;

	typedef struct packed {
		odc_in_t  reading;
		logic     typed;
		odc_out_t readout;
	} steer_row_t;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 250;
	localparam longint TPM_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam longint TPM_MIN = -TPM_MAX - 1;
	localparam longint RPM_MAX = 32767;
	localparam longint RPM_MIN = -32768;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	odc_in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	odc_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TPR_W-1:0] cfg_data;

	logic [TPR_W-1:0]  odo_tpr;
	logic [MASK_W-1:0] odo_rev;
	logic [MASK_W-1:0] odo_last_a;
	logic [CNT_W-1:0]  odo_count [MAX_WHEELS];
	logic [CNT_W-1:0]  odo_snap [MAX_WHEELS];
	logic [CNT_W-1:0]  odo_speed [MAX_WHEELS];
	logic [2:0]        odo_polls;
	odc_out_t pending_readouts [$];

	int mismatches = 0;
	int send_idle = 16;
	int recv_idle = 58;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	logic [MASK_W-1:0] sent_a = '0;
	logic [MASK_W-1:0] spin_b = 4'b0101;

	wheel_odometry_counter_top dut (.*);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic odc_out_t predict_readout(input odc_in_t r);
		logic [MASK_W-1:0] rise;
		longint diff;
		longint rate;
		longint turns;
		odc_out_t res;
		rise = r.a_levels & ~odo_last_a;
		for (int w = 0; w < MAX_WHEELS; w++) begin
			if (rise[w]) begin
				if (r.b_levels[w] == odo_rev[w])
					odo_count[w] = odo_count[w] + 1;
				else
					odo_count[w] = odo_count[w] - 1;
			end
		end
		odo_last_a = r.a_levels;
		// clear lands after the edge count, so it wins
		if (r.clear_wheel) begin
			odo_count[r.wheel] = '0;
			odo_snap[r.wheel] = '0;
		end
		if (r.poll_tick) begin
			odo_polls = odo_polls + 3'd1;
			if (odo_polls >= POLL_LIMIT) begin
				for (int w = 0; w < MAX_WHEELS; w++) begin
					diff = longint'($signed(odo_count[w])) - longint'($signed(odo_snap[w]));
					rate = (diff / 5) * 600;
					if (rate > TPM_MAX)
						rate = TPM_MAX;
					else if (rate < TPM_MIN)
						rate = TPM_MIN;
					odo_speed[w] = rate[CNT_W-1:0];
					odo_snap[w] = odo_count[w];
				end
				odo_polls = '0;
			end
		end
		turns = 0;
		if (odo_tpr != '0) begin
			turns = longint'($signed(odo_speed[r.wheel])) / longint'(odo_tpr);
			if (turns > RPM_MAX)
				turns = RPM_MAX;
			else if (turns < RPM_MIN)
				turns = RPM_MIN;
		end
		res.ticks = odo_count[r.wheel];
		res.ticks_per_minute = odo_speed[r.wheel];
		res.rpm = turns[RPM_W-1:0];
		return res;
	endfunction

	function automatic steer_row_t step_row(input logic [MASK_W-1:0] a, input logic [MASK_W-1:0] b,
			input logic p, input logic c, input logic [WHEEL_W-1:0] w, input logic typed,
			input logic signed [CNT_W-1:0] tk, input logic signed [CNT_W-1:0] tm,
			input int rp);
		steer_row_t row;
		row.reading.a_levels = a;
		row.reading.b_levels = b;
		row.reading.poll_tick = p;
		row.reading.clear_wheel = c;
		row.reading.wheel = w;
		row.typed = typed;
		row.readout.ticks = tk;
		row.readout.ticks_per_minute = tm;
		row.readout.rpm = RPM_W'(rp);
		return row;
	endfunction

	// spin: toggle A on most requests with a mostly steady B, poll on a fixed period
	function automatic odc_in_t make_reading(input bit spin, input int k, input int poll_every);
		odc_in_t r;
		if (spin) begin
			r.a_levels = ($urandom_range(19) != 0) ? ~sent_a : MASK_W'($urandom_range(15));
			r.b_levels = ($urandom_range(19) != 0) ? spin_b : MASK_W'($urandom_range(15));
			r.poll_tick = (k % poll_every == poll_every - 1);
			r.clear_wheel = ($urandom_range(299) == 0);
		end else begin
			r.a_levels = MASK_W'($urandom_range(15));
			r.b_levels = MASK_W'($urandom_range(15));
			r.poll_tick = ($urandom_range(9) == 0);
			r.clear_wheel = ($urandom_range(15) == 0);
		end
		r.wheel = WHEEL_W'($urandom_range(3));
		sent_a = r.a_levels;
		return r;
	endfunction

	task automatic send_reading(input odc_in_t r, input bit typed, input odc_out_t typed_out);
		odc_out_t guess;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		guess = predict_readout(r);
		pending_readouts.push_back(typed ? typed_out : guess);
	endtask

	task automatic drain_readouts;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_readouts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TPR_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == REG_TICKS_PER_REV)
			odo_tpr = val;
		else
			odo_rev = val[MASK_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold off the out channel for a long stretch when asked
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		odc_out_t want;
		if (out_valid && out_ready) begin
			if (pending_readouts.size() == 0) begin
				$display("%0t unexpected readout: ticks %0d tpm %0d rpm %0d", $time,
					out_data.ticks, out_data.ticks_per_minute, out_data.rpm);
				mismatches++;
			end else begin
				want = pending_readouts.pop_front();
				if (out_data.ticks !== want.ticks) begin
					$display("%0t ticks: expected %0d, actual %0d", $time,
						want.ticks, out_data.ticks);
					mismatches++;
				end
				if (out_data.ticks_per_minute !== want.ticks_per_minute) begin
					$display("%0t ticks_per_minute: expected %0d, actual %0d", $time,
						want.ticks_per_minute, out_data.ticks_per_minute);
					mismatches++;
				end
				if (out_data.rpm !== want.rpm) begin
					$display("%0t rpm: expected %0d, actual %0d", $time,
						want.rpm, out_data.rpm);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		steer_row_t steer [22];
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		odo_tpr = TPR_RESET;
		odo_rev = MASK_RESET;
		odo_last_a = '0;
		odo_polls = '0;
		for (int w = 0; w < MAX_WHEELS; w++) begin
			odo_count[w] = '0;
			odo_snap[w] = '0;
			odo_speed[w] = '0;
		end
		steer = '{
			step_row(4'h0, 4'h0, 1'b0, 1'b0, 2'd0, 1'b1, 0, 0, 0),
			step_row(4'hF, 4'h0, 1'b0, 1'b0, 2'd0, 1'b1, 1, 0, 0),
			step_row(4'h0, 4'hF, 1'b0, 1'b0, 2'd1, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'hF, 1'b0, 1'b0, 2'd2, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'h0, 1'b0, 1'b0, 2'd3, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'hA, 1'b0, 1'b1, 2'd0, 1'b1, 0, 0, 0),
			step_row(4'h0, 4'h5, 1'b1, 1'b0, 2'd1, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'h5, 1'b1, 1'b0, 2'd2, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'h0, 1'b1, 1'b0, 2'd3, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'h0, 1'b1, 1'b0, 2'd0, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'hF, 1'b1, 1'b1, 2'd1, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'hF, 1'b0, 1'b0, 2'd1, 1'b0, 0, 0, 0),
			step_row(4'h5, 4'hA, 1'b0, 1'b0, 2'd2, 1'b0, 0, 0, 0),
			step_row(4'hA, 4'h5, 1'b0, 1'b0, 2'd3, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'hF, 1'b0, 1'b1, 2'd3, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'h0, 1'b0, 1'b0, 2'd0, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'h0, 1'b1, 1'b0, 2'd3, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'h0, 1'b1, 1'b0, 2'd0, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'hF, 1'b1, 1'b0, 2'd2, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'h0, 1'b1, 1'b0, 2'd1, 1'b0, 0, 0, 0),
			step_row(4'hF, 4'h0, 1'b1, 1'b0, 2'd0, 1'b0, 0, 0, 0),
			step_row(4'h0, 4'h0, 1'b0, 1'b1, 2'd2, 1'b0, 0, 0, 0)
		};
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(steer); i++)
			send_reading(steer[i].reading, steer[i].typed, steer[i].readout);
		for (int k = 0; k < 200; k++)
			send_reading(make_reading(1'b0, k, 1), 1'b0, '0);
		drain_readouts();

		// fast spin at one tick per rev: drive rpm into saturation both ways
		send_idle = 58;
		recv_idle = 16;
		write_reg(REG_TICKS_PER_REV, 16'd1);
		write_reg(REG_REVERSE_MASK, 16'd0);
		spin_b = 4'b0101;
		for (int k = 0; k < 720; k++)
			send_reading(make_reading(1'b1, k, 120), 1'b0, '0);
		drain_readouts();

		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_TICKS_PER_REV, 16'd0);
		write_reg(REG_REVERSE_MASK, 16'd15);
		hold_req = 1'b1;
		for (int k = 0; k < 150; k++)
			send_reading(make_reading(1'b0, k, 1), 1'b0, '0);
		drain_readouts();

		write_reg(REG_TICKS_PER_REV, 16'hFFFF);
		write_reg(REG_REVERSE_MASK, 16'd5);
		for (int k = 0; k < 120; k++)
			send_reading(make_reading(1'b0, k, 1), 1'b0, '0);
		drain_readouts();

		write_reg(REG_TICKS_PER_REV, TPR_W'($urandom_range(300, 1)));
		write_reg(REG_REVERSE_MASK, TPR_W'($urandom_range(15)));
		spin_b = MASK_W'($urandom_range(15));
		for (int k = 0; k < 120; k++)
			send_reading(make_reading(1'b1, k, 10), 1'b0, '0);
		drain_readouts();

		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
